// File: rtl/media_header_fragmenter_defines.svh
// Assertion macros for the media header fragmenter.
// Included by the top level; no other dependencies.
`ifndef MEDIA_HEADER_FRAGMENTER_DEFINES_SVH
`define MEDIA_HEADER_FRAGMENTER_DEFINES_SVH
`ifndef SYNTHESIS
`define MHF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mhf: implication check failed");
`define MHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mhf: next-cycle check failed");
`else
`define MHF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define MHF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/mhf_pkg.sv
// Shared types and constants of the media header fragmenter.
// No dependencies.
`timescale 1ns / 1ps
package mhf_pkg;

    localparam int HEADER_BYTES = 36;
    localparam int HDR_BITS     = HEADER_BYTES * 8;
    localparam int HDR_CNT_W    = 6;
    localparam int S_TDATA_W    = 360;
    localparam int M_TDATA_W    = 88;
    localparam logic [15:0] CFG_RESET = 16'd1024;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_DATA  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] track_id;
        logic [63:0] pts;
        logic [63:0] dts;
        logic [63:0] duration;
        logic [7:0]  media_type;
        logic [7:0]  media_flag;
        logic [7:0]  bit_format;
        logic [7:0]  packet_type;
        logic [31:0] data_size;
        logic [63:0] stamp;
        logic [7:0]  data_byte;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic pop;
        logic hdr_busy;
    } t_back_stat;

endpackage

// File: rtl/mhf_front.sv
// Front end: accepts input words, unpacks them and drops excess data bytes.
// Depends on mhf_pkg.
`timescale 1ns / 1ps
module mhf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mhf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  mhf_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output mhf_pkg::t_entry               o_entry
);
    import mhf_pkg::*;

    // data bytes still expected for the current packet
    logic [31:0] r_data_left;
    logic [31:0] n_data_left;
    logic        accept;

    assign s_axis_tready = !i_q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        o_entry.kind        = t_kind'(s_axis_tuser);
        o_entry.track_id    = s_axis_tdata[31:0];
        o_entry.pts         = s_axis_tdata[95:32];
        o_entry.dts         = s_axis_tdata[159:96];
        o_entry.duration    = s_axis_tdata[223:160];
        o_entry.media_type  = s_axis_tdata[231:224];
        o_entry.media_flag  = s_axis_tdata[239:232];
        o_entry.bit_format  = s_axis_tdata[247:240];
        o_entry.packet_type = s_axis_tdata[255:248];
        o_entry.data_size   = s_axis_tdata[287:256];
        o_entry.stamp       = s_axis_tdata[351:288];
        o_entry.data_byte   = s_axis_tdata[359:352];
    end

    always_comb begin
        o_push      = 1'b0;
        n_data_left = r_data_left;
        if (accept) begin
            if (o_entry.kind == KIND_START) begin
                o_push      = 1'b1;
                n_data_left = o_entry.data_size;
            end else if (r_data_left != 32'd0) begin
                o_push      = 1'b1;
                n_data_left = r_data_left - 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_left <= 32'd0;
        end else begin
            r_data_left <= n_data_left;
        end
    end

endmodule

// File: rtl/mhf_queue.sv
// Short FIFO between front and back end.
// Depends on mhf_pkg.
`timescale 1ns / 1ps
module mhf_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mhf_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output mhf_pkg::t_entry  o_entry,
    output mhf_pkg::t_q_stat o_stat
);
    import mhf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_entry      = r_mem[r_rd_ptr];

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        bump = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= bump(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= bump(r_rd_ptr);
            if (do_push && !do_pop)      r_count <= r_count + CW'(1);
            else if (do_pop && !do_push) r_count <= r_count - CW'(1);
        end
    end

endmodule

// File: rtl/mhf_back.sv
// Back end: expands headers, fragments the byte stream, drives the output register.
// Depends on mhf_pkg.
`timescale 1ns / 1ps
module mhf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [15:0]                   i_max_frag,
    input  mhf_pkg::t_entry               i_entry,
    input  mhf_pkg::t_q_stat              i_q_stat,
    output mhf_pkg::t_back_stat           o_stat,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mhf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);
    import mhf_pkg::*;

    logic [15:0]          r_seq;
    logic [32:0]          r_rem;
    logic [15:0]          r_fill;
    logic [63:0]          r_stamp;
    logic [HDR_BITS-1:0]  r_hdr;
    logic [HDR_CNT_W-1:0] r_hdr_cnt;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [15:0] r_out_seq;
    logic [63:0] r_out_stamp;
    logic        r_out_marker;
    logic        r_out_last;

    logic        adv;
    logic        hdr_busy;
    logic        pop;
    logic        emit_hdr;
    logic        emit;
    logic        load_start;
    logic [7:0]  emit_byte;
    logic [15:0] maxb;
    logic [15:0] slot;
    logic        frag_last;
    logic        marker;
    logic [15:0] seq_out;

    assign adv        = !r_out_valid || m_axis_tready;
    assign hdr_busy   = (r_hdr_cnt != '0);
    assign pop        = adv && !hdr_busy && !i_q_stat.empty;
    assign emit_hdr   = adv && hdr_busy;
    assign load_start = pop && (i_entry.kind == KIND_START);
    assign emit       = emit_hdr || (pop && (i_entry.kind == KIND_DATA) && (r_rem != 33'd0));
    assign emit_byte  = emit_hdr ? r_hdr[HDR_BITS-1 -: 8] : i_entry.data_byte;

    assign o_stat.pop      = pop;
    assign o_stat.hdr_busy = hdr_busy;

    // fragment bookkeeping for the byte going out this cycle
    always_comb begin
        maxb      = (i_max_frag == 16'd0) ? 16'd1 : i_max_frag;
        slot      = (maxb > r_fill) ? (maxb - r_fill) : 16'd1;
        frag_last = (({1'b0, r_fill} + 17'd1) >= {1'b0, maxb}) || (r_rem == 33'd1);
        marker    = (r_rem <= {17'd0, slot});
        seq_out   = (r_fill == 16'd0) ? r_seq : (r_seq - 16'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= 16'd0;
            r_rem       <= 33'd0;
            r_fill      <= 16'd0;
            r_stamp     <= 64'd0;
            r_hdr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_start) begin
                r_hdr_cnt <= HDR_CNT_W'(HEADER_BYTES);
                r_rem     <= 33'(HEADER_BYTES) + {1'b0, i_entry.data_size};
                r_fill    <= 16'd0;
                r_stamp   <= i_entry.stamp;
            end else if (emit) begin
                if (emit_hdr) r_hdr_cnt <= r_hdr_cnt - HDR_CNT_W'(1);
                if (r_fill == 16'd0) r_seq <= r_seq + 16'd1;
                r_rem  <= r_rem - 33'd1;
                r_fill <= frag_last ? 16'd0 : (r_fill + 16'd1);
            end
            if (adv) r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_start) begin
            r_hdr <= {i_entry.track_id, i_entry.pts, i_entry.dts, i_entry.duration,
                      i_entry.media_type, i_entry.media_flag, i_entry.bit_format,
                      i_entry.packet_type, i_entry.data_size};
        end else if (emit_hdr) begin
            r_hdr <= {r_hdr[HDR_BITS-9:0], 8'd0};
        end
        if (adv && emit) begin
            r_out_byte   <= emit_byte;
            r_out_seq    <= seq_out;
            r_out_stamp  <= r_stamp;
            r_out_marker <= marker;
            r_out_last   <= frag_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_stamp, r_out_seq, r_out_byte};
    assign m_axis_tuser  = r_out_marker;
    assign m_axis_tlast  = r_out_last;

endmodule

// File: rtl/media_header_fragmenter.sv
// Top level of the media header fragmenter: config register, front, queue, back.
// Depends on mhf_pkg, mhf_front, mhf_queue, mhf_back, media_header_fragmenter_defines.svh.
//
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+--------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata 360b, tuser = kind
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata 88b, tuser marker, tlast
// cfg       | in        | i_cfg_valid/o_cfg_ready      | max_fragment_bytes (16b)
//
// The back end emits one byte per cycle while the output is not stalled.
// A start word first loads the header shift register, then the back end emits
// 36 header bytes; the front keeps accepting into the queue meanwhile.
// Reset (synchronous, active low) clears sequence, counters, queue, output valid;
// max_fragment_bytes returns to 1024. A stalled output holds the output register
// and, once the queue fills, s_axis_tready drops.
`timescale 1ns / 1ps
`include "media_header_fragmenter_defines.svh"
module media_header_fragmenter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, low bit up: track_id[31:0], pts[95:32], dts[159:96], duration[223:160],
    // media_type[231:224], media_flag[239:232], bit_format[247:240],
    // packet_type[255:248], data_size[287:256], stamp[351:288], data_byte[359:352]
    input  logic [mhf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: kind (0 start, 1 data byte)
    input  logic                          s_axis_tuser,
    // master stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata, low bit up: out_byte[7:0], sequence_res[23:8], fragment_stamp[87:24]
    output logic [mhf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: marker (word lies in the packet's final fragment)
    output logic                          m_axis_tuser,
    // tlast: fragment_end
    output logic                          m_axis_tlast,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [15:0]                   i_cfg_data
);
    import mhf_pkg::*;

    logic [15:0] r_max_frag;
    logic        push;
    t_entry      front_entry;
    t_entry      q_entry;
    t_q_stat     q_stat;
    t_back_stat  back_stat;

    // user must write config only while idle (not enforced here), so the back end reads it directly
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frag <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_frag <= i_cfg_data;
        end
    end

    mhf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_entry       (front_entry)
    );

    mhf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (back_stat.pop),
        .o_entry (q_entry),
        .o_stat  (q_stat)
    );

    mhf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_frag    (r_max_frag),
        .i_entry       (q_entry),
        .i_q_stat      (q_stat),
        .o_stat        (back_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // front never pushes into a full queue
    `MHF_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, push, !q_stat.full)
    // back end only pops a non-empty queue
    `MHF_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, back_stat.pop, !q_stat.empty)
    // header expansion blocks the queue until all 36 bytes are out
    `MHF_ASSERT_IMPLY(a_hdr_blocks_pop, i_clk, i_rst_n, back_stat.hdr_busy, !back_stat.pop)
    // a popped start word begins header expansion on the next cycle
    `MHF_ASSERT_NEXT(a_start_loads_hdr, i_clk, i_rst_n,
        back_stat.pop && (q_entry.kind == KIND_START), back_stat.hdr_busy)

endmodule
